>>> hdl/aprd_pkg.sv
`timescale 1ns / 1ps

package aprd_pkg;

    localparam logic [7:0] PREAMBLE_FIRST  = 8'h41;
    localparam logic [7:0] PREAMBLE_SECOND = 8'h42;
    localparam logic [7:0] REUSE_YES       = 8'h01;
    localparam logic [7:0] TRAILER_BYTE    = 8'h00;

    localparam logic [7:0] BODY_CHUNK_CODE_RST   = 8'd3;
    localparam logic [7:0] END_RESPONSE_CODE_RST = 8'd5;

    typedef enum logic [1:0] {
        REG_BODY_CHUNK_CODE   = 2'd0,
        REG_END_RESPONSE_CODE = 2'd1,
        REG_KEEP_CONNECTION   = 2'd2
    } reg_index_t;

    typedef enum logic [2:0] {
        KIND_FRAME   = 3'd0,
        KIND_DATA    = 3'd1,
        KIND_TRAILER = 3'd2,
        KIND_END     = 3'd3,
        KIND_ERROR   = 3'd4
    } kind_t;

    typedef struct packed {
        logic [7:0] body_chunk_code;
        logic [7:0] end_response_code;
        logic       keep_connection;
    } cfg_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] payload;
        logic       chunk_last;
        logic       reuse_flag;
        logic       keepalive;
    } result_t;

endpackage

>>> hdl/ajp_response_chunk_deframer_top.sv
`timescale 1ns / 1ps
// Each result is formed combinationally and registered into the output buffer.
// Throughput: one item per cycle while s_tready is high; the parse state advances
// on every accepted byte. A two-entry output register keeps input accepted while
// one result waits. Reset: aresetn synchronous, active low; clears parser state,
// sticky error, output buffer and restores register defaults (3, 5, 0).
module ajp_response_chunk_deframer_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // in_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // payload, reuse_flag, keepalive, zero fill
    output logic [2:0]  m_tuser,   // kind
    output logic        m_tlast,   // chunk_last
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import aprd_pkg::*;

    cfg_t    cfg_reg;
    result_t parse_result;
    result_t out_item;
    logic    in_fire;

    assign cfg_ready = 1'b1;
    assign in_fire   = s_tvalid & s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.body_chunk_code   <= BODY_CHUNK_CODE_RST;
            cfg_reg.end_response_code <= END_RESPONSE_CODE_RST;
            cfg_reg.keep_connection   <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_BODY_CHUNK_CODE:   cfg_reg.body_chunk_code   <= cfg_data;
                REG_END_RESPONSE_CODE: cfg_reg.end_response_code <= cfg_data;
                REG_KEEP_CONNECTION:   cfg_reg.keep_connection   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    aprd_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (in_fire),
        .in_byte (s_tdata),
        .cfg     (cfg_reg),
        .result  (parse_result)
    );

    aprd_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (parse_result),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (out_item)
    );

    assign m_tdata = {6'd0, out_item.keepalive, out_item.reuse_flag, out_item.payload};
    assign m_tuser = out_item.kind;
    assign m_tlast = out_item.chunk_last;

    // hold input only when a result is already waiting
    assert property (@(posedge aclk) disable iff (!aresetn) !s_tready |-> m_tvalid)
        else $error("input stalled with empty output");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tuser == KIND_DATA))
        else $error("chunk_last on non-payload item");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[8] || m_tdata[9])) |-> (m_tuser == KIND_END))
        else $error("reuse flags on non-end item");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[9]) |-> m_tdata[8])
        else $error("keepalive without reuse");

endmodule

>>> hdl/aprd_parser.sv
`timescale 1ns / 1ps

module aprd_parser (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step,
    input  logic [7:0]       in_byte,
    input  aprd_pkg::cfg_t    cfg,
    output aprd_pkg::result_t result
);
    import aprd_pkg::*;

    typedef enum logic [8:0] {
        ST_PRE1    = 9'b000000001,
        ST_PRE2    = 9'b000000010,
        ST_PLEN_HI = 9'b000000100,
        ST_PLEN_LO = 9'b000001000,
        ST_TYPE    = 9'b000010000,
        ST_DLEN_HI = 9'b000100000,
        ST_DLEN_LO = 9'b001000000,
        ST_DATA    = 9'b010000000,
        ST_REUSE   = 9'b100000000
    } state_t;

    state_t      state_reg, state_next;
    logic [7:0]  length_high_reg, length_high_next;
    logic [15:0] remaining_reg, remaining_next;
    logic        trailer_reg, trailer_next;
    logic        error_reg, error_next;

    always_comb begin
        state_next       = state_reg;
        length_high_next = length_high_reg;
        remaining_next   = remaining_reg;
        trailer_next     = trailer_reg;
        error_next       = error_reg;
        result           = '0;
        result.kind      = KIND_FRAME;

        if (error_reg) begin
            result.kind = KIND_ERROR;
        end else begin
            case (state_reg)
                ST_PRE2: begin
                    if (in_byte == PREAMBLE_SECOND) begin
                        state_next = ST_PLEN_HI;
                    end else begin
                        result.kind = KIND_ERROR;
                        error_next  = 1'b1;
                    end
                end
                ST_PLEN_HI: state_next = ST_PLEN_LO;
                ST_PLEN_LO: state_next = ST_TYPE;
                ST_TYPE: begin
                    if (in_byte == cfg.body_chunk_code) begin
                        state_next = ST_DLEN_HI;
                    end else if (in_byte == cfg.end_response_code) begin
                        state_next = ST_REUSE;
                    end else begin
                        result.kind = KIND_ERROR;
                        error_next  = 1'b1;
                    end
                end
                ST_DLEN_HI: begin
                    length_high_next = in_byte;
                    state_next       = ST_DLEN_LO;
                end
                ST_DLEN_LO: begin
                    remaining_next   = {length_high_reg, in_byte};
                    length_high_next = '0;
                    trailer_next     = 1'b1;
                    state_next       = ({length_high_reg, in_byte} != '0) ? ST_DATA : ST_PRE1;
                end
                ST_DATA: begin
                    result.kind    = KIND_DATA;
                    result.payload = in_byte;
                    remaining_next = remaining_reg - 16'd1;
                    if (remaining_next == '0) begin
                        result.chunk_last = 1'b1;
                        state_next        = ST_PRE1;
                    end
                end
                ST_REUSE: begin
                    result.kind       = KIND_END;
                    result.reuse_flag = (in_byte == REUSE_YES);
                    result.keepalive  = (in_byte == REUSE_YES) & cfg.keep_connection;
                    state_next        = ST_PRE1;
                end
                default: begin
                    trailer_next = 1'b0;
                    if (trailer_reg && in_byte == TRAILER_BYTE) begin
                        result.kind = KIND_TRAILER;
                        state_next  = ST_PRE1;
                    end else if (in_byte == PREAMBLE_FIRST) begin
                        state_next = ST_PRE2;
                    end else begin
                        state_next  = ST_PRE1;
                        result.kind = KIND_ERROR;
                        error_next  = 1'b1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_PRE1;
            length_high_reg <= '0;
            remaining_reg   <= '0;
            trailer_reg     <= 1'b0;
            error_reg       <= 1'b0;
        end else if (step) begin
            state_reg       <= state_next;
            length_high_reg <= length_high_next;
            remaining_reg   <= remaining_next;
            trailer_reg     <= trailer_next;
            error_reg       <= error_next;
        end
    end

endmodule

>>> hdl/aprd_out_buf.sv
`timescale 1ns / 1ps

module aprd_out_buf (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  aprd_pkg::result_t in_item,
    output logic              out_valid,
    input  logic              out_ready,
    output aprd_pkg::result_t out_item
);
    import aprd_pkg::*;

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_reg;
    result_t skid_reg;
    logic    in_fire;
    logic    out_take;

    assign in_ready  = !skid_valid_reg;
    assign in_fire   = in_valid & in_ready;
    assign out_take  = out_valid_reg & out_ready;
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (out_take) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (in_fire) begin
            if (!out_valid_reg || out_take) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (out_take) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (out_take) begin
                out_reg <= skid_reg;
            end
        end else if (in_fire) begin
            if (!out_valid_reg || out_take) begin
                out_reg <= in_item;
            end else begin
                skid_reg <= in_item;
            end
        end
    end

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import aprd_pkg::*;

    localparam longint CYCLE_LIMIT = 20_000_000;
    localparam int     MAX_REPORTS = 50;

    typedef enum logic [3:0] {
        PS_PRE1,
        PS_PRE2,
        PS_PLEN_HI,
        PS_PLEN_LO,
        PS_TYPE,
        PS_DLEN_HI,
        PS_DLEN_LO,
        PS_DATA,
        PS_REUSE
    } parse_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = REG_BODY_CHUNK_CODE;
    logic [7:0]  cfg_data = 8'h00;

    ajp_response_chunk_deframer_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // deframer shadow state
    cfg_t        cfg_shadow = {BODY_CHUNK_CODE_RST, END_RESPONSE_CODE_RST, 1'b0};
    parse_t      pst = PS_PRE1;
    logic [7:0]  len_hi_hold = 8'h00;
    logic [15:0] rem_bytes = 16'h0000;
    logic        trailer_due = 1'b0;
    logic        err_sticky = 1'b0;

    logic [7:0]  stream_bytes[$];
    result_t     pending_results[$];
    result_t     want;
    result_t     got;

    logic        s_took = 1'b0;
    int          src_gap = 0;
    int          src_calm = 0;
    int          snk_gap = 0;
    int          snk_calm = 0;
    int          fail_count = 0;
    int          queued_total = 0;
    int          n_settings = 1;
    int          kind_seen[5] = '{0, 0, 0, 0, 0};
    int          n_chunk_ends = 0;
    longint      cycle_count = 0;

    function automatic result_t deframe_byte(input logic [7:0] b);
        result_t r;
        r = '0;
        r.kind = KIND_FRAME;
        if (err_sticky) begin
            r.kind = KIND_ERROR;
        end else begin
            case (pst)
                PS_PRE2: begin
                    if (b == PREAMBLE_SECOND) begin
                        pst = PS_PLEN_HI;
                    end else begin
                        r.kind = KIND_ERROR;
                        err_sticky = 1'b1;
                    end
                end
                PS_PLEN_HI: pst = PS_PLEN_LO;
                PS_PLEN_LO: pst = PS_TYPE;
                PS_TYPE: begin
                    if (b == cfg_shadow.body_chunk_code) begin
                        pst = PS_DLEN_HI;
                    end else if (b == cfg_shadow.end_response_code) begin
                        pst = PS_REUSE;
                    end else begin
                        r.kind = KIND_ERROR;
                        err_sticky = 1'b1;
                    end
                end
                PS_DLEN_HI: begin
                    len_hi_hold = b;
                    pst = PS_DLEN_LO;
                end
                PS_DLEN_LO: begin
                    rem_bytes = {len_hi_hold, b};
                    len_hi_hold = 8'h00;
                    trailer_due = 1'b1;
                    pst = (rem_bytes != 16'h0000) ? PS_DATA : PS_PRE1;
                end
                PS_DATA: begin
                    r.kind = KIND_DATA;
                    r.payload = b;
                    rem_bytes = rem_bytes - 16'd1;
                    if (rem_bytes == 16'h0000) begin
                        r.chunk_last = 1'b1;
                        pst = PS_PRE1;
                    end
                end
                PS_REUSE: begin
                    r.kind = KIND_END;
                    r.reuse_flag = (b == REUSE_YES);
                    r.keepalive = r.reuse_flag & cfg_shadow.keep_connection;
                    pst = PS_PRE1;
                end
                default: begin
                    if (trailer_due && b == TRAILER_BYTE) begin
                        trailer_due = 1'b0;
                        r.kind = KIND_TRAILER;
                        pst = PS_PRE1;
                    end else begin
                        trailer_due = 1'b0;
                        if (b == PREAMBLE_FIRST) begin
                            pst = PS_PRE2;
                        end else begin
                            pst = PS_PRE1;
                            r.kind = KIND_ERROR;
                            err_sticky = 1'b1;
                        end
                    end
                end
            endcase
        end
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // source side: hold until taken, then idle or advance
    always @(negedge aclk) begin
        logic       nxt_valid;
        logic [7:0] nxt_data;
        nxt_valid = s_tvalid;
        nxt_data = s_tdata;
        if (!aresetn) begin
            nxt_valid = 1'b0;
        end else if (!s_tvalid || s_took) begin
            nxt_valid = 1'b0;
            if (src_gap > 0) begin
                src_gap = src_gap - 1;
            end else if (stream_bytes.size() > 0) begin
                nxt_data = stream_bytes.pop_front();
                nxt_valid = 1'b1;
                if (src_calm > 0) begin
                    src_calm = src_calm - 1;
                end else begin
                    src_gap = pick_gap();
                    if ($urandom_range(0, 63) == 0) src_calm = $urandom_range(20, 80);
                end
            end
        end
        s_tvalid <= nxt_valid;
        s_tdata <= nxt_data;
    end

    // sink side backpressure
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (snk_gap > 0) begin
            snk_gap = snk_gap - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (snk_calm > 0) begin
                snk_calm = snk_calm - 1;
            end else if ($urandom_range(0, 3) == 0) begin
                snk_gap = pick_gap();
                if ($urandom_range(0, 31) == 0) snk_calm = $urandom_range(20, 80);
            end
        end
    end

    always @(posedge aclk) begin
        s_took <= aresetn && s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready) pending_results.push_back(deframe_byte(s_tdata));
        if (aresetn && m_tvalid && m_tready) begin
            got.kind = kind_t'(m_tuser);
            got.payload = m_tdata[7:0];
            got.chunk_last = m_tlast;
            got.reuse_flag = m_tdata[8];
            got.keepalive = m_tdata[9];
            if (pending_results.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("%0t: unexpected result kind=%0d payload=%02h", $time,
                             got.kind, got.payload);
            end else begin
                want = pending_results.pop_front();
                if (want.kind <= KIND_ERROR) kind_seen[want.kind]++;
                if (want.chunk_last) n_chunk_ends++;
                if (got != want || m_tdata[15:10] != 6'd0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $display("%0t: expected kind=%0d payload=%02h last=%0b reuse=%0b keep=%0b",
                                 $time, want.kind, want.payload, want.chunk_last,
                                 want.reuse_flag, want.keepalive);
                        $display("%0t: got kind=%0d payload=%02h last=%0b reuse=%0b keep=%0b fill=%02h",
                                 $time, got.kind, got.payload, got.chunk_last,
                                 got.reuse_flag, got.keepalive, m_tdata[15:10]);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("run timed out after %0d cycles", cycle_count);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic push_byte(input logic [7:0] b);
        stream_bytes.push_back(b);
        queued_total++;
    endtask

    task automatic add_header(input logic [7:0] type_code);
        push_byte(PREAMBLE_FIRST);
        push_byte(PREAMBLE_SECOND);
        push_byte(8'($urandom_range(0, 255)));
        push_byte(8'($urandom_range(0, 255)));
        push_byte(type_code);
    endtask

    task automatic add_chunk(input int unsigned len, input bit with_trailer);
        logic [15:0] l16;
        l16 = len[15:0];
        add_header(cfg_shadow.body_chunk_code);
        push_byte(l16[15:8]);
        push_byte(l16[7:0]);
        repeat (len) push_byte(8'($urandom_range(0, 255)));
        if (with_trailer) push_byte(TRAILER_BYTE);
    endtask

    task automatic add_end(input logic [7:0] reuse_byte);
        add_header(cfg_shadow.end_response_code);
        push_byte(reuse_byte);
    endtask

    task automatic add_random_packet();
        int r;
        int s;
        int unsigned len;
        r = $urandom_range(0, 99);
        if (r < 65 || cfg_shadow.body_chunk_code == cfg_shadow.end_response_code) begin
            s = $urandom_range(0, 99);
            if (s < 60) len = $urandom_range(0, 4);
            else if (s < 92) len = $urandom_range(5, 32);
            else len = $urandom_range(33, 300);
            add_chunk(len, 1'($urandom_range(0, 1)));
        end else if ($urandom_range(0, 1) == 1) begin
            add_end(REUSE_YES);
        end else begin
            add_end(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic fill_random(input int budget);
        int start;
        start = queued_total;
        while (queued_total - start < budget) add_random_packet();
    endtask

    // one framing fault, then noise while the error holds
    task automatic add_broken_tail();
        int pick;
        logic [7:0] b;
        pick = $urandom_range(0, 2);
        if (pick == 0) begin
            do b = 8'($urandom_range(0, 255));
            while (b == PREAMBLE_FIRST || b == TRAILER_BYTE);
            push_byte(b);
        end else if (pick == 1) begin
            push_byte(PREAMBLE_FIRST);
            do b = 8'($urandom_range(0, 255));
            while (b == PREAMBLE_SECOND);
            push_byte(b);
        end else begin
            do b = 8'($urandom_range(0, 255));
            while (b == cfg_shadow.body_chunk_code || b == cfg_shadow.end_response_code);
            add_header(b);
        end
        repeat (40) push_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic settle();
        while (stream_bytes.size() != 0 || s_tvalid || pending_results.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [7:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_BODY_CHUNK_CODE:   cfg_shadow.body_chunk_code = val;
            REG_END_RESPONSE_CODE: cfg_shadow.end_response_code = val;
            REG_KEEP_CONNECTION:   cfg_shadow.keep_connection = val[0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_config(input logic [7:0] body, input logic [7:0] endc,
                              input logic keep);
        write_reg(REG_BODY_CHUNK_CODE, body);
        write_reg(REG_END_RESPONSE_CODE, endc);
        write_reg(REG_KEEP_CONNECTION, {7'd0, keep});
        n_settings++;
    endtask

    initial begin
        logic [7:0] code_a;
        logic [7:0] code_b;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        // zero-length chunk with trailer, short chunk without, end packets
        add_chunk(0, 1'b1);
        add_header(cfg_shadow.body_chunk_code);
        push_byte(8'h00);
        push_byte(8'h02);
        push_byte(8'h00);
        push_byte(8'hFF);
        add_end(REUSE_YES);
        add_end(8'h00);
        fill_random(280);
        settle();

        set_config(8'h00, 8'hFF, 1'b1);
        fill_random(300);
        settle();

        set_config(8'hFF, 8'h00, 1'b0);
        fill_random(300);
        settle();

        code_a = 8'($urandom_range(0, 255));
        set_config(code_a, code_a, 1'b1);
        fill_random(260);
        settle();

        code_a = 8'($urandom_range(0, 255));
        do code_b = 8'($urandom_range(0, 255));
        while (code_b == code_a);
        set_config(code_a, code_b, 1'b1);
        add_chunk(16'h0105, 1'b1);
        fill_random(200);
        add_broken_tail();
        settle();

        repeat (10) @(posedge aclk);
        $display("covered %0d payload bytes in %0d chunks, %0d end packets, %0d trailers",
                 kind_seen[KIND_DATA], n_chunk_ends, kind_seen[KIND_END],
                 kind_seen[KIND_TRAILER]);
        $display("%0d framing bytes, %0d error results, %0d register settings, %0d failures",
                 kind_seen[KIND_FRAME], kind_seen[KIND_ERROR], n_settings, fail_count);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

>>> ajp_response_chunk_deframer_top.f
hdl/aprd_pkg.sv
hdl/aprd_parser.sv
hdl/aprd_out_buf.sv
hdl/ajp_response_chunk_deframer_top.sv
verif/tb_top.sv
